[rtl/homography_bilinear_warp_assert.svh]
// assertion macros for the homography bilinear warp block
`ifndef HOMOGRAPHY_BILINEAR_WARP_ASSERT_SVH
`define HOMOGRAPHY_BILINEAR_WARP_ASSERT_SVH

// same-cycle implication
`define HBW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbw assertion failed");

// next-cycle implication
`define HBW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbw assertion failed");

`endif

[rtl/hbw_pkg.sv]
// shared constants and types for the homography bilinear warp block
package hbw_pkg;

    localparam int MAX_SRC_W   = 1024;
    localparam int MAX_SRC_H   = 1024;
    localparam int CANVAS_BITS = 13;

    localparam int X_BITS     = $clog2(MAX_SRC_W);
    localparam int Y_BITS     = $clog2(MAX_SRC_H);
    localparam int BANK_AW    = X_BITS + Y_BITS - 2;
    localparam int BANK_DEPTH = (MAX_SRC_W / 2) * (MAX_SRC_H / 2);
    localparam int DIM_W      = 14;

    localparam int LOAD_BITS = 10;
    localparam int PIX_W     = 32;
    localparam int CFG_W     = 64;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = COEF_W + CANVAS_BITS + 1;
    localparam int NUM_W     = PROD_W + 2;

    localparam int QFRAC   = 20;
    localparam int QINT    = 24;
    localparam int QBITS   = QFRAC + QINT;
    localparam int T_W     = QBITS + 2;
    localparam int DIV_LAT = QBITS + 3;
    localparam int SX_W    = T_W + 1;
    localparam int FRAC    = 8;
    localparam int WGT_W   = 2 * FRAC + 1;
    localparam int MUL_W   = WGT_W + 8;
    localparam int ACC_W   = MUL_W + 2;

    typedef enum logic [2:0] {
        REG_COEF_ROW0_A    = 3'd0,
        REG_COEF_ROW0_ROW1 = 3'd1,
        REG_COEF_ROW1_B    = 3'd2,
        REG_COEF_ROW2_A    = 3'd3,
        REG_COEF_ROW2_C    = 3'd4,
        REG_SOURCE_WIDTH   = 3'd5,
        REG_SOURCE_HEIGHT  = 3'd6,
        REG_CROP_OFFSETS   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                   warp;
        logic [CANVAS_BITS-1:0] cx;
        logic [CANVAS_BITS-1:0] cy;
        logic [LOAD_BITS-1:0]   lx;
        logic [LOAD_BITS-1:0]   ly;
        logic [PIX_W-1:0]       rgba;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  wpos;
    } dly_t;

    typedef struct packed {
        logic [PIX_W-1:0]       rgba;
        logic                   in_src;
        logic [CANVAS_BITS-1:0] x;
        logic [CANVAS_BITS-1:0] y;
    } out_t;

endpackage

[rtl/hbw_ram.sv]
// generic single-write, single-read ram with registered read data
module hbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/hbw_div.sv]
// pipelined restoring divider, floor of num * 2^20 / den with saturation
module hbw_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [hbw_pkg::NUM_W-1:0] num,
    input  logic        [hbw_pkg::NUM_W-1:0] den,
    output logic signed [hbw_pkg::T_W-1:0]   quo
);
    import hbw_pkg::*;

    logic             neg0_reg;
    logic [NUM_W-1:0] a0_reg;
    logic [NUM_W-1:0] b0_reg;
    logic             sat0;

    logic [NUM_W-1:0] r_reg   [QBITS+1];
    logic [NUM_W-1:0] b_reg   [QBITS+1];
    logic [QBITS-1:0] dv_reg  [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             sat_reg [QBITS+1];

    logic [NUM_W-1:0] r_next [QBITS+1];
    logic [QBITS-1:0] q_next [QBITS+1];
    logic [NUM_W:0]   rs     [QBITS+1];
    logic             ge     [QBITS+1];

    logic [QBITS:0]   qmag;
    logic             rnz;

    assign sat0 = {{QINT{1'b0}}, a0_reg} >= {b0_reg, {QINT{1'b0}}};

    always_comb
    begin
        r_next[0] = '0;
        q_next[0] = '0;
        rs[0]     = '0;
        ge[0]     = 1'b0;
        for (int j = 1; j <= QBITS; j++)
        begin
            rs[j]     = {r_reg[j-1], dv_reg[j-1][QBITS-j]};
            ge[j]     = rs[j] >= {1'b0, b_reg[j-1]};
            r_next[j] = ge[j] ? NUM_W'(rs[j] - {1'b0, b_reg[j-1]}) : NUM_W'(rs[j]);
            q_next[j] = q_reg[j-1] | (QBITS'(ge[j]) << (QBITS - j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg <= num[NUM_W-1];
            a0_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            b0_reg   <= den;

            r_reg[0]   <= sat0 ? '0 : (a0_reg >> QINT);
            b_reg[0]   <= b0_reg;
            dv_reg[0]  <= {a0_reg[QINT-1:0], {QFRAC{1'b0}}};
            q_reg[0]   <= '0;
            neg_reg[0] <= neg0_reg;
            sat_reg[0] <= sat0;

            for (int j = 1; j <= QBITS; j++)
            begin
                r_reg[j]   <= r_next[j];
                b_reg[j]   <= b_reg[j-1];
                dv_reg[j]  <= dv_reg[j-1];
                q_reg[j]   <= q_next[j];
                neg_reg[j] <= neg_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
            end

            quo <= neg_reg[QBITS] ? (-T_W'(qmag)) - T_W'(rnz) : T_W'(qmag);
        end
    end

    assign qmag = sat_reg[QBITS] ? ((QBITS+1)'(1) << QBITS) : {1'b0, q_reg[QBITS]};
    assign rnz  = !sat_reg[QBITS] && (r_reg[QBITS] != '0);

endmodule

[rtl/homography_bilinear_warp.sv]
// top level of the homography bilinear warp block
// Usage:
//  input channel (in_valid/in_ready): action 0 loads load_rgba into the frame
//  store at (load_x, load_y) and gives no result; action 1 warps canvas pixel
//  (canvas_x, canvas_y) and gives one result item on the output channel
//  (out_valid/out_ready) with out_rgba, inside_res and the echoed canvas position.
//  configuration: cfg_we writes cfg_wdata into register cfg_index; the user must
//  write only when idle, as the block does not enforce it. throughput: one item
//  per cycle, back to back, while in_ready is high. a warp item passes from
//  acceptance to out_valid through the product and sum stages, the 44-step
//  quotient pipeline, and the multiply, address, frame store read and blend stages.
//  the frame store is four parity banks, so the four neighbours are read in the
//  same cycle; a load writes at the same stage where warps read, so order is kept.
//  reset: h00 = 1, h11 = 0x10000, h22 = 0x1000_0000, other coefficients zero,
//  1024 x 1024 source, zero crop; frame store contents undefined until loaded.
//  stall: a two-item output buffer lets the pipeline keep accepting while one
//  result waits; in_ready drops only when the buffer is full.
module homography_bilinear_warp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [hbw_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [hbw_pkg::LOAD_BITS-1:0]   load_x,
    input  logic [hbw_pkg::LOAD_BITS-1:0]   load_y,
    input  logic [hbw_pkg::PIX_W-1:0]       load_rgba,
    input  logic [hbw_pkg::CANVAS_BITS-1:0] canvas_x,
    input  logic [hbw_pkg::CANVAS_BITS-1:0] canvas_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hbw_pkg::PIX_W-1:0]       out_rgba,
    output logic                            inside_res,
    output logic [hbw_pkg::CANVAS_BITS-1:0] out_x,
    output logic [hbw_pkg::CANVAS_BITS-1:0] out_y
);
    import hbw_pkg::*;

    `include "homography_bilinear_warp_assert.svh"

    // configuration
    logic [CFG_W-1:0]  coef0_reg;
    logic [CFG_W-1:0]  coef1_reg;
    logic [CFG_W-1:0]  coef2_reg;
    logic [CFG_W-1:0]  coef3_reg;
    logic [COEF_W-1:0] h22_reg;
    logic [10:0]       src_w_reg;
    logic [10:0]       src_h_reg;
    logic [31:0]       crop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef0_reg <= 64'h0000_0001_0000_0000;
            coef1_reg <= '0;
            coef2_reg <= 64'h0001_0000_0000_0000;
            coef3_reg <= '0;
            h22_reg   <= 32'h1000_0000;
            src_w_reg <= 11'd1024;
            src_h_reg <= 11'd1024;
            crop_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF_ROW0_A:    coef0_reg <= cfg_wdata;
                REG_COEF_ROW0_ROW1: coef1_reg <= cfg_wdata;
                REG_COEF_ROW1_B:    coef2_reg <= cfg_wdata;
                REG_COEF_ROW2_A:    coef3_reg <= cfg_wdata;
                REG_COEF_ROW2_C:    h22_reg   <= cfg_wdata[COEF_W-1:0];
                REG_SOURCE_WIDTH:   src_w_reg <= cfg_wdata[10:0];
                REG_SOURCE_HEIGHT:  src_h_reg <= cfg_wdata[10:0];
                REG_CROP_OFFSETS:   crop_reg  <= cfg_wdata[31:0];
                default:            crop_reg  <= crop_reg;
            endcase
        end
    end

    logic [DIM_W-1:0] wid;
    logic [DIM_W-1:0] hei;
    assign wid = (DIM_W'(src_w_reg) < DIM_W'(MAX_SRC_W)) ? DIM_W'(src_w_reg) : DIM_W'(MAX_SRC_W);
    assign hei = (DIM_W'(src_h_reg) < DIM_W'(MAX_SRC_H)) ? DIM_W'(src_h_reg) : DIM_W'(MAX_SRC_H);

    // flow control
    logic [1:0] cnt_reg;
    logic       pipe_en;
    logic       in_acc;

    assign pipe_en  = (cnt_reg != 2'd2);
    assign in_ready = pipe_en;
    assign in_acc   = in_valid && pipe_en;

    // stage 1: products
    logic                     v1_reg;
    side_t                    s1_reg;
    logic signed [PROD_W-1:0] pw0_reg, pw1_reg, px0_reg, px1_reg, py0_reg, py1_reg;
    logic signed [CANVAS_BITS:0] cxs, cys;

    assign cxs = {1'b0, canvas_x};
    assign cys = {1'b0, canvas_y};

    // stage 2: sums
    logic                    v2s_reg;
    side_t                   s2s_reg;
    logic signed [NUM_W-1:0] w_reg, nx_reg, ny_reg;
    logic                    wpos;

    assign wpos = !w_reg[NUM_W-1] && (w_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2s_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg  <= in_acc;
            v2s_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_reg  <= '{warp: action, cx: canvas_x, cy: canvas_y, lx: load_x, ly: load_y,
                         rgba: load_rgba};
            pw0_reg <= PROD_W'($signed(coef3_reg[63:32]) * cxs);
            pw1_reg <= PROD_W'($signed(coef3_reg[31:0]) * cys);
            px0_reg <= PROD_W'($signed(coef0_reg[63:32]) * cxs);
            px1_reg <= PROD_W'($signed(coef0_reg[31:0]) * cys);
            py0_reg <= PROD_W'($signed(coef1_reg[31:0]) * cxs);
            py1_reg <= PROD_W'($signed(coef2_reg[63:32]) * cys);

            s2s_reg <= s1_reg;
            w_reg   <= NUM_W'(pw0_reg) + NUM_W'(pw1_reg) + NUM_W'($signed(h22_reg));
            nx_reg  <= NUM_W'(px0_reg) + NUM_W'(px1_reg) + NUM_W'($signed(coef1_reg[63:32]));
            ny_reg  <= NUM_W'(py0_reg) + NUM_W'(py1_reg) + NUM_W'($signed(coef2_reg[31:0]));
        end
    end

    // quotients
    logic signed [T_W-1:0] tx, ty;

    hbw_div u_div_x (
        .clk (clk),
        .en  (pipe_en),
        .num (nx_reg),
        .den (NUM_W'(w_reg)),
        .quo (tx)
    );

    hbw_div u_div_y (
        .clk (clk),
        .en  (pipe_en),
        .num (ny_reg),
        .den (NUM_W'(w_reg)),
        .quo (ty)
    );

    logic vd_reg [DIV_LAT];
    dly_t sd_reg [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vd_reg[0] <= v2s_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sd_reg[0] <= '{side: s2s_reg, wpos: wpos};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // stage e1: crop offset
    logic                   ve1_reg;
    dly_t                   se1_reg;
    logic signed [SX_W-1:0] sx_reg, sy_reg;

    // stage e2: position, clamps, frame store access
    logic                  ve2_reg;
    side_t                 se2_reg;
    logic                  ins2_reg;
    logic [X_BITS-1:0]     x0_reg;
    logic [Y_BITS-1:0]     y0_reg;
    logic [FRAC-1:0]       fx_reg, fy_reg;
    logic                  clx2_reg, cly2_reg;

    logic                  ins_c;
    logic [SX_W-2-FRAC:0]  sxi, syi;

    assign sxi   = sx_reg[SX_W-2:FRAC];
    assign syi   = sy_reg[SX_W-2:FRAC];
    assign ins_c = se1_reg.wpos && !sx_reg[SX_W-1] && !sy_reg[SX_W-1]
                   && (sxi < (SX_W-1-FRAC)'(wid)) && (syi < (SX_W-1-FRAC)'(hei));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve1_reg <= 1'b0;
            ve2_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            ve1_reg <= vd_reg[DIV_LAT-1];
            ve2_reg <= ve1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            se1_reg  <= sd_reg[DIV_LAT-1];
            sx_reg   <= SX_W'(tx) + SX_W'({crop_reg[31:16], {FRAC{1'b0}}});
            sy_reg   <= SX_W'(ty) + SX_W'({crop_reg[15:0], {FRAC{1'b0}}});

            se2_reg  <= se1_reg.side;
            ins2_reg <= ins_c;
            x0_reg   <= sx_reg[FRAC+X_BITS-1:FRAC];
            y0_reg   <= sy_reg[FRAC+Y_BITS-1:FRAC];
            fx_reg   <= sx_reg[FRAC-1:0];
            fy_reg   <= sy_reg[FRAC-1:0];
            clx2_reg <= (DIM_W'(sx_reg[FRAC+X_BITS-1:FRAC]) + DIM_W'(1)) >= wid;
            cly2_reg <= (DIM_W'(sy_reg[FRAC+Y_BITS-1:FRAC]) + DIM_W'(1)) >= hei;
        end
    end

    // frame store, four banks by column and row parity
    logic [X_BITS-1:0]  lxe;
    logic [Y_BITS-1:0]  lye;
    logic               load_ok;
    logic               ld_we;
    logic [BANK_AW-1:0] ld_addr;
    logic [X_BITS-2:0]  col_e, col_o;
    logic [Y_BITS-2:0]  row_e, row_o;
    logic [PIX_W-1:0]   bank_rd [4];

    assign lxe     = X_BITS'(se2_reg.lx);
    assign lye     = Y_BITS'(se2_reg.ly);
    assign load_ok = (DIM_W'(se2_reg.lx) < DIM_W'(MAX_SRC_W))
                     && (DIM_W'(se2_reg.ly) < DIM_W'(MAX_SRC_H));
    assign ld_we   = pipe_en && ve2_reg && !se2_reg.warp && load_ok;
    assign ld_addr = {lye[Y_BITS-1:1], lxe[X_BITS-1:1]};
    assign col_o   = x0_reg[X_BITS-1:1];
    assign col_e   = x0_reg[X_BITS-1:1] + (X_BITS-1)'(x0_reg[0]);
    assign row_o   = y0_reg[Y_BITS-1:1];
    assign row_e   = y0_reg[Y_BITS-1:1] + (Y_BITS-1)'(y0_reg[0]);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [BANK_AW-1:0] rd_addr;
        assign rd_addr = {(b / 2 == 1) ? row_o : row_e, (b % 2 == 1) ? col_o : col_e};

        hbw_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (ld_we && (lye[0] == 1'(b / 2)) && (lxe[0] == 1'(b % 2))),
            .waddr (ld_addr),
            .wdata (se2_reg.rgba),
            .re    (pipe_en),
            .raddr (rd_addr),
            .rdata (bank_rd[b])
        );
    end

    // stage e3: weights, read data arrives
    logic                   ve3_reg;
    logic                   warp3_reg, ins3_reg, clx3_reg, cly3_reg, xp3_reg, yp3_reg;
    logic [CANVAS_BITS-1:0] cx3_reg, cy3_reg;
    logic [WGT_W-1:0]       wt3_reg [4];
    logic [FRAC:0]          fxc, fyc;

    assign fxc = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(fx_reg);
    assign fyc = (FRAC+1)'(1 << FRAC) - (FRAC+1)'(fy_reg);

    // stage e4: channel products
    logic                   ve4_reg;
    logic                   warp4_reg, ins4_reg;
    logic [CANVAS_BITS-1:0] cx4_reg, cy4_reg;
    logic [MUL_W-1:0]       pr4_reg [4][4];

    logic [PIX_W-1:0] p00, p10, p01, p11, q10, q01, q11;
    logic [PIX_W-1:0] nb [4];

    assign p00 = yp3_reg ? (xp3_reg ? bank_rd[3] : bank_rd[2])
                         : (xp3_reg ? bank_rd[1] : bank_rd[0]);
    assign q10 = yp3_reg ? (xp3_reg ? bank_rd[2] : bank_rd[3])
                         : (xp3_reg ? bank_rd[0] : bank_rd[1]);
    assign q01 = yp3_reg ? (xp3_reg ? bank_rd[1] : bank_rd[0])
                         : (xp3_reg ? bank_rd[3] : bank_rd[2]);
    assign q11 = yp3_reg ? (xp3_reg ? bank_rd[0] : bank_rd[1])
                         : (xp3_reg ? bank_rd[2] : bank_rd[3]);
    assign p10 = clx3_reg ? p00 : q10;
    assign p01 = cly3_reg ? p00 : q01;
    assign p11 = clx3_reg ? p01 : (cly3_reg ? p10 : q11);
    assign nb[0] = p00;
    assign nb[1] = p10;
    assign nb[2] = p01;
    assign nb[3] = p11;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve3_reg <= 1'b0;
            ve4_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            ve3_reg <= ve2_reg;
            ve4_reg <= ve3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            warp3_reg  <= se2_reg.warp;
            ins3_reg   <= ins2_reg;
            clx3_reg   <= clx2_reg;
            cly3_reg   <= cly2_reg;
            xp3_reg    <= x0_reg[0];
            yp3_reg    <= y0_reg[0];
            cx3_reg    <= se2_reg.cx;
            cy3_reg    <= se2_reg.cy;
            wt3_reg[0] <= WGT_W'(fxc * fyc);
            wt3_reg[1] <= WGT_W'({1'b0, fx_reg} * fyc);
            wt3_reg[2] <= WGT_W'(fxc * {1'b0, fy_reg});
            wt3_reg[3] <= WGT_W'({1'b0, fx_reg} * {1'b0, fy_reg});

            warp4_reg <= warp3_reg;
            ins4_reg  <= ins3_reg;
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;
            for (int n = 0; n < 4; n++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    pr4_reg[n][c] <= MUL_W'(wt3_reg[n] * nb[n][8*c +: 8]);
                end
            end
        end
    end

    // blend, round, clamp
    logic [ACC_W-1:0] acc_c [4];
    logic [ACC_W-1:0] rnd_c [4];
    logic [PIX_W-1:0] pix_c;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_c[c] = ACC_W'(pr4_reg[0][c]) + ACC_W'(pr4_reg[1][c])
                     + ACC_W'(pr4_reg[2][c]) + ACC_W'(pr4_reg[3][c])
                     + ACC_W'(1 << (2 * FRAC - 1));
            rnd_c[c] = acc_c[c] >> (2 * FRAC);
            pix_c[8*c +: 8] = (rnd_c[c] > ACC_W'(255)) ? 8'hff : rnd_c[c][7:0];
        end
    end

    // output buffer
    out_t fifo_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic push, pop;
    out_t res_c;

    assign push  = pipe_en && ve4_reg && warp4_reg;
    assign pop   = out_valid && out_ready;
    assign res_c = '{rgba: ins4_reg ? pix_c : '0, in_src: ins4_reg, x: cx4_reg, y: cy4_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res_c;
        end
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign out_rgba   = fifo_reg[rd_ptr_reg].rgba;
    assign inside_res = fifo_reg[rd_ptr_reg].in_src;
    assign out_x      = fifo_reg[rd_ptr_reg].x;
    assign out_y      = fifo_reg[rd_ptr_reg].y;

    `HBW_ASSERT_SAME(a_black_outside, out_valid && !inside_res, out_rgba == '0)
    `HBW_ASSERT_SAME(a_buf_bound, 1'b1, cnt_reg != 2'd3)
    `HBW_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(ve4_reg) && $stable(ve1_reg))

endmodule
